>>> hw/rtl/spc_pkg.sv
// Package with shared widths and constants for the sphere pair collision block.
`default_nettype none
package spc_pkg;
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned COORD_W   = 32;
    localparam int unsigned RAD_W     = 31;
    localparam int unsigned DIFF_W    = 33;
    localparam int unsigned MAG_W     = 33;
    localparam int unsigned SQ_W      = 68;
    localparam int unsigned ROOT_W    = 34;
    localparam int unsigned OV_W      = 32;
    localparam int unsigned PROD_W    = 65;
    localparam int unsigned QUO_W     = 33;
    localparam int unsigned IN_W      = 256;
    localparam int unsigned OUT_W     = 192;
endpackage
`default_nettype wire

>>> hw/rtl/sphere_pair_collision_top.sv
// Top level of the sphere pair collision block: a fully pipelined resolver.
//
// Each input beat carries two spheres (centres, radii, fixed flags) and each
// output beat carries the resolved centres and an overlapped flag. The block
// accepts one beat in every cycle while the output register is empty or being
// taken. In order the stages compute the differences, squares and sum, the
// restoring square root (one result bit per stage), the overlap and the
// multiply, then 33 divider stages (the first aligns the numerator, each of the
// others yields one quotient bit) and the output register, ahead of which the last
// quotient bit is settled. The whole pipeline advances together whenever the
// output register is empty or being taken, so a stall loses and repeats nothing.
// All arithmetic works on the raw coordinate values, so the fraction width
// (spc_pkg::FRAC_BITS) only sets how the numbers are read.
`default_nettype none
module sphere_pair_collision_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // a_x, a_y, a_z, a_radius, a_fixed, b_x, b_y, b_z, b_radius, b_fixed
    input  wire logic [255:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z
    output logic [191:0]     m_tdata,
    // overlapped
    output logic             m_tuser
);
    localparam int unsigned RW = spc_pkg::ROOT_W;
    localparam int unsigned QW = spc_pkg::QUO_W;
    localparam int unsigned PW = spc_pkg::PROD_W;
    localparam int unsigned SW = spc_pkg::SQ_W;

    typedef struct packed {
        logic signed [31:0] ax, ay, az, bx, by, bz;
        logic               afix, bfix;
    } geo_t;

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Stage 1: unpack, differences.
    geo_t               g_in;
    logic [31:0]        rsum_in;
    logic signed [32:0] d_in [3];
    always_comb begin
        g_in.ax   = s_tdata[31:0];
        g_in.ay   = s_tdata[63:32];
        g_in.az   = s_tdata[95:64];
        g_in.afix = s_tdata[127];
        g_in.bx   = s_tdata[159:128];
        g_in.by   = s_tdata[191:160];
        g_in.bz   = s_tdata[223:192];
        g_in.bfix = s_tdata[255];
        rsum_in   = {1'b0, s_tdata[126:96]} + {1'b0, s_tdata[254:224]};
        d_in[0]   = 33'(g_in.ax) - 33'(g_in.bx);
        d_in[1]   = 33'(g_in.ay) - 33'(g_in.by);
        d_in[2]   = 33'(g_in.az) - 33'(g_in.bz);
    end

    localparam int unsigned S1W = $bits(geo_t) + 32 + 99;
    logic           v1;
    logic [S1W-1:0] p1;
    spc_pipe #(.W(S1W)) u_s1 (.aclk, .aresetn, .en(adv), .vin(s_tvalid),
        .din({g_in, rsum_in, d_in[0], d_in[1], d_in[2]}), .vout(v1), .dout(p1));

    geo_t               g1;
    logic [31:0]        rs1;
    logic signed [32:0] d1 [3];
    assign {g1, rs1, d1[0], d1[1], d1[2]} = p1;

    // Stage 2: squares of the magnitudes (32 x 32 each).
    logic [63:0] sq_n [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [32:0] m;
            m = d1[i][32] ? 33'(-d1[i]) : d1[i];
            sq_n[i] = 64'(m[31:0]) * 64'(m[31:0]);
        end
    end
    // Magnitudes are below 2^32 since both coordinates are 32-bit signed.
    localparam int unsigned S2W = $bits(geo_t) + 32 + 99 + 192;
    logic           v2;
    logic [S2W-1:0] p2;
    spc_pipe #(.W(S2W)) u_s2 (.aclk, .aresetn, .en(adv), .vin(v1),
        .din({p1, sq_n[0], sq_n[1], sq_n[2]}), .vout(v2), .dout(p2));

    logic [S1W-1:0] q2;
    logic [63:0]    sq2 [3];
    assign {q2, sq2[0], sq2[1], sq2[2]} = p2;

    // Stage 3: sum of squares.
    logic [SW-1:0] n3_next;
    assign n3_next = SW'(sq2[0]) + SW'(sq2[1]) + SW'(sq2[2]);
    logic                v3;
    logic [S1W+SW-1:0]   p3;
    spc_pipe #(.W(S1W+SW)) u_s3 (.aclk, .aresetn, .en(adv), .vin(v2),
        .din({q2, n3_next}), .vout(v3), .dout(p3));

    // Square root stages: restoring, one bit per stage (remainder form).
    localparam int unsigned RMW = RW + 2;
    logic [S1W-1:0] rq   [RW+1];
    logic [SW-1:0]  rn   [RW+1];
    logic [RMW-1:0] rrem [RW+1];
    logic [RW-1:0]  rroot[RW+1];
    logic           rv   [RW+1];
    assign rq[0]    = p3[S1W+SW-1:SW];
    assign rn[0]    = p3[SW-1:0];
    assign rrem[0]  = '0;
    assign rroot[0] = '0;
    assign rv[0]    = v3;

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        logic [RMW-1:0] rem_sh, trial, rem_n;
        logic [RW-1:0]  root_n;
        logic [SW-1:0]  n_n;
        localparam int unsigned TOT = S1W + SW + RMW + RW;
        logic [TOT-1:0] o;
        always_comb begin
            rem_sh = {rrem[k][RMW-3:0], rn[k][SW-1:SW-2]};
            trial  = {rroot[k], 2'b01};
            n_n    = {rn[k][SW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_n  = rem_sh - trial;
                root_n = {rroot[k][RW-2:0], 1'b1};
            end else begin
                rem_n  = rem_sh;
                root_n = {rroot[k][RW-2:0], 1'b0};
            end
        end
        spc_pipe #(.W(TOT)) u_r (.aclk, .aresetn, .en(adv), .vin(rv[k]),
            .din({rq[k], n_n, rem_n, root_n}), .vout(rv[k+1]), .dout(o));
        assign {rq[k+1], rn[k+1], rrem[k+1], rroot[k+1]} = o;
    end

    // Overlap and multiply, first stage: overlap, hit and move flags.
    geo_t               gm;
    logic [31:0]        rsm;
    logic signed [32:0] dm [3];
    logic [RW-1:0]      root_dist;
    logic signed [35:0] ov_full;
    logic               hit, mv;
    logic [31:0]        ovm;
    always_comb begin
        {gm, rsm, dm[0], dm[1], dm[2]} = rq[RW];
        root_dist = rroot[RW];
        ov_full   = 36'(rsm) - 36'(root_dist);
        hit       = !ov_full[35] && (ov_full != '0);
        mv        = hit && (root_dist != '0);
        ovm       = ov_full[31:0];
    end
    // When the spheres move, the distance is below the radius sum, so 33 bits hold it.
    localparam int unsigned M1W = $bits(geo_t) + 99 + 33 + 32 + 2;
    logic           vm1;
    logic [M1W-1:0] pm1;
    spc_pipe #(.W(M1W)) u_m1 (.aclk, .aresetn, .en(adv), .vin(rv[RW]),
        .din({gm, dm[0], dm[1], dm[2], root_dist[32:0], ovm, hit, mv}),
        .vout(vm1), .dout(pm1));

    geo_t               g5;
    logic signed [32:0] d5 [3];
    logic [32:0]        dist5;
    logic [31:0]        ov5;
    logic               hit5, mv5;
    assign {g5, d5[0], d5[1], d5[2], dist5, ov5, hit5, mv5} = pm1;

    // Multiply stage: |d| * ov, one 32 x 32 product per axis.
    logic [63:0] pr_n [3];
    logic        neg_n [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [32:0] m;
            m        = d5[i][32] ? 33'(-d5[i]) : d5[i];
            pr_n[i]  = 64'(m[31:0]) * 64'(ov5);
            neg_n[i] = d5[i][32];
        end
    end
    localparam int unsigned M2W = $bits(geo_t) + 33 + 2 + 3 + 192;
    logic           vm2;
    logic [M2W-1:0] pm2;
    spc_pipe #(.W(M2W)) u_m2 (.aclk, .aresetn, .en(adv), .vin(vm1),
        .din({g5, dist5, hit5, mv5, neg_n[0], neg_n[1], neg_n[2],
              pr_n[0], pr_n[1], pr_n[2]}), .vout(vm2), .dout(pm2));

    // Divider stages: restoring, three lanes sharing the divisor 2*dist.
    localparam int unsigned DVW = QW + 1;
    localparam int unsigned CW  = $bits(geo_t) + 5;
    logic [CW-1:0]  dc  [QW+1];
    logic [PW-1:0]  dden[QW+1];
    logic [DVW-1:0] dr  [QW+1][3];
    logic [63:0]    dn  [QW+1][3];
    logic [QW-1:0]  dq  [QW+1][3];
    logic           dv  [QW+1];
    assign dc[0] = {pm2[M2W-1 -: $bits(geo_t)], pm2[192 +: 5]};
    assign dv[0] = vm2;
    assign dden[0] = PW'({pm2[192+5 +: 33], 1'b0});
    for (genvar i = 0; i < 3; i++) begin : g_dinit
        assign dn[0][i] = pm2[(2-i)*64 +: 64];
        assign dr[0][i] = '0;
        assign dq[0][i] = '0;
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [DVW-1:0] r_n [3];
        logic [63:0]    n_n [3];
        logic [QW-1:0]  q_n [3];
        localparam int unsigned TOT = CW + PW + 3 * (DVW + 64 + QW);
        logic [TOT-1:0] o;
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                logic [DVW:0] sh;
                // The quotient stays below 2^33, so the top 31 numerator bits
                // are loaded straight into the remainder.
                if (k == 0) begin
                    sh = (DVW+1)'(dn[k][i][63:33]);
                    n_n[i] = {dn[k][i][32:0], 31'b0};
                end else begin
                    sh = {dr[k][i], dn[k][i][63]};
                    n_n[i] = {dn[k][i][62:0], 1'b0};
                end
                if (k == 0) begin
                    r_n[i] = DVW'(sh);
                    q_n[i] = '0;
                end else if ((PW)'(sh) >= dden[k]) begin
                    r_n[i] = DVW'((PW)'(sh) - dden[k]);
                    q_n[i] = {dq[k][i][QW-2:0], 1'b1};
                end else begin
                    r_n[i] = DVW'(sh);
                    q_n[i] = {dq[k][i][QW-2:0], 1'b0};
                end
            end
        end
        spc_pipe #(.W(TOT)) u_d (.aclk, .aresetn, .en(adv), .vin(dv[k]),
            .din({dc[k], dden[k], r_n[0], n_n[0], q_n[0], r_n[1], n_n[1], q_n[1],
                  r_n[2], n_n[2], q_n[2]}), .vout(dv[k+1]), .dout(o));
        assign {dc[k+1], dden[k+1], dr[k+1][0], dn[k+1][0], dq[k+1][0],
                dr[k+1][1], dn[k+1][1], dq[k+1][1],
                dr[k+1][2], dn[k+1][2], dq[k+1][2]} = o;
    end

    // Final division bit, apply shifts and saturate into the output register.
    geo_t        gf;
    logic        hitf, mvf;
    logic        negf [3];
    logic [191:0] res_n;
    function automatic logic [31:0] sat34(input logic signed [35:0] v);
        if (v > 36'sh7FFFFFFF)       return 32'h7FFFFFFF;
        else if (v < -36'sh80000000) return 32'h80000000;
        else                         return v[31:0];
    endfunction
    always_comb begin
        logic [QW-1:0] q;
        logic [DVW:0]  sh;
        logic signed [35:0] s, a, b;
        {gf, hitf, mvf, negf[0], negf[1], negf[2]} = dc[QW];
        for (int i = 0; i < 3; i++) begin
            sh = {dr[QW][i], dn[QW][i][63]};
            q  = ((PW)'(sh) >= dden[QW]) ? {dq[QW][i][QW-2:0], 1'b1}
                                         : {dq[QW][i][QW-2:0], 1'b0};
            s  = mvf ? (negf[i] ? -36'(q) : 36'(q)) : 36'sd0;
            case (i)
                0:       begin a = 36'(gf.ax); b = 36'(gf.bx); end
                1:       begin a = 36'(gf.ay); b = 36'(gf.by); end
                default: begin a = 36'(gf.az); b = 36'(gf.bz); end
            endcase
            res_n[i*32 +: 32]     = sat34(gf.afix ? a : a + s);
            res_n[96+i*32 +: 32]  = sat34(gf.bfix ? b : b - s);
        end
    end

    logic [192:0] outp;
    spc_pipe #(.W(193)) u_out (.aclk, .aresetn, .en(adv), .vin(dv[QW]),
        .din({hitf, res_n}), .vout(m_tvalid), .dout(outp));
    assign m_tdata = outp[191:0];
    assign m_tuser = outp[192];

    // A waiting result holds while the consumer stalls.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    // The input side is open exactly when the pipeline can advance.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready out of step with the output register");
    // No overlap means the centres pass through (checked here on a_x).
    a_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        dv[QW] && adv && !hitf |=> m_tdata[31:0] == $past(gf.ax))
        else $error("non-overlapping pair moved");
endmodule
`default_nettype wire

>>> hw/rtl/spc_pipe.sv
// Generic stall-aware pipeline stage register with a valid bit.
`default_nettype none
module spc_pipe #(
    parameter int unsigned W = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         en,
    input  wire logic         vin,
    input  wire logic [W-1:0] din,
    output logic              vout,
    output logic [W-1:0]      dout
);
    logic         v_reg;
    logic [W-1:0] d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= vin;
        end
        if (en) begin
            d_reg <= din;
        end
    end

    assign vout = v_reg;
    assign dout = d_reg;
endmodule
`default_nettype wire
